// ===== sv/interlaced_two_bit_rle_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// Interlaced two-bit RLE decoder - assertion macros
// Shared concurrent assertion forms for the checker of the decoder top level.
// ----------------------------------------------------------------------------
`ifndef INTERLACED_TWO_BIT_RLE_DECODER_TOP_DEFINES_SVH
`define INTERLACED_TWO_BIT_RLE_DECODER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset
`define ITRLE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ITRLE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/itrle_pkg.sv =====
// ----------------------------------------------------------------------------
// itrle_pkg - shared types and constants
// Field widths, register codes, run record type and symbol extraction for
// the interlaced two-bit RLE decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package itrle_pkg;

   // Field widths
   localparam int unsigned DIM_W    = 10;
   localparam int unsigned ROW_W    = DIM_W + 1;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned SYM_W    = 2;
   localparam int unsigned LEN_W    = 3;
   localparam int unsigned ADDR_W   = 3;
   localparam int unsigned DATA_W   = 32;

   // Largest bitmap dimension; register values above it are clamped
   localparam int unsigned MAX_DIMENSION = 1023;
   localparam logic [DIM_W-1:0] DIM_LIMIT =
      (MAX_DIMENSION > 1023) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIMENSION);

   // Rows advance by two: one field covers every other row
   localparam logic [ROW_W-1:0] ROW_STEP = ROW_W'(2);

   // Configuration register codes (word index within the register map)
   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // Configuration as seen by the decoder
   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
   } cfg_type;

   // One run record
   typedef struct packed {
      logic [DIM_W-1:0] pixel_row;
      logic [DIM_W-1:0] pixel_column;
      logic [SYM_W-1:0] color_index;
      logic [LEN_W-1:0] run_length;
      logic             last_of_byte;
   } run_type;

   // Decoder to output stage: a run to load and its strobe
   typedef struct packed {
      logic    emit;
      run_type run;
   } step_type;

   // Symbol at position pos of a byte, most significant first
   function automatic logic [SYM_W-1:0] get_symbol(input logic [BYTE_W-1:0] b,
                                                   input logic [1:0] pos);
      logic [SYM_W-1:0] sym;
      case (pos)
         2'd0:    sym = b[7:6];
         2'd1:    sym = b[5:4];
         2'd2:    sym = b[3:2];
         default: sym = b[1:0];
      endcase
      return sym;
   endfunction

endpackage

`default_nettype wire

// ===== sv/itrle_if.sv =====
// ----------------------------------------------------------------------------
// itrle_if - stream channels of the decoder
// Request channel carrying compressed bytes and response channel carrying
// run records, each with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface itrle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       begin_field;
   logic       field_index;

   modport source (output valid, output data_byte, output begin_field,
                   output field_index, input ready);
   modport sink   (input valid, input data_byte, input begin_field,
                   input field_index, output ready);
endinterface

interface itrle_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] pixel_row;
   logic [9:0] pixel_column;
   logic [1:0] color_index;
   logic [2:0] run_length;
   logic       last_of_byte;

   modport source (output valid, output pixel_row, output pixel_column,
                   output color_index, output run_length, output last_of_byte,
                   input ready);
   modport sink   (input valid, input pixel_row, input pixel_column,
                   input color_index, input run_length, input last_of_byte,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/itrle_csr.sv =====
// ----------------------------------------------------------------------------
// itrle_csr - configuration registers
// APB-style register port holding bitmap width and height.
// ----------------------------------------------------------------------------
`default_nettype none

module itrle_csr
   import itrle_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             wr_en;
   reg_index_type    reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = reg_index_type'(paddr[2]);

   // Decode write
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_IMAGE_WIDTH:  width_in  = pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[DIM_W-1:0];
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_sel)
         REG_IMAGE_WIDTH:  prdata = DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: prdata = DATA_W'(height_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Clamp to the supported bitmap size
   assign cfg.image_width  = (width_ff > DIM_LIMIT) ? DIM_LIMIT : width_ff;
   assign cfg.image_height = (height_ff > DIM_LIMIT) ? DIM_LIMIT : height_ff;

endmodule

`default_nettype wire

// ===== sv/itrle_decode.sv =====
// ----------------------------------------------------------------------------
// itrle_decode - byte register and run decoder
// Holds the current byte and the raster position, and decodes one run per
// cycle from the held byte while the output stage is free.
// ----------------------------------------------------------------------------
`default_nettype none

module itrle_decode
   import itrle_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [BYTE_W-1:0] in_data_byte,
   input  wire logic              in_begin_field,
   input  wire logic              in_field_index,
   input  wire logic              out_free,
   output step_type               step
);

   // Held byte
   logic              hold_valid_ff, hold_valid_in;
   logic [BYTE_W-1:0] hold_byte_ff, hold_byte_in;
   logic [1:0]        hold_pos_ff, hold_pos_in;
   logic              hold_begin_ff, hold_begin_in;
   logic              hold_field_ff, hold_field_in;

   // Raster state
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic              pending_ff, pending_in;
   logic              active_ff, active_in;

   // Decode temporaries
   logic              go;
   logic              done;
   logic [ROW_W-1:0]  eff_row;
   logic [DIM_W-1:0]  eff_col;
   logic              eff_pending;
   logic              eff_active;
   logic [SYM_W-1:0]  sym0, sym1, sym_last;
   logic [SYM_W-1:0]  color;
   logic [SYM_W-1:0]  count;
   logic              take_run;
   logic [2:0]        consume;
   logic [LEN_W-1:0]  len_raw, len;
   logic [DIM_W-1:0]  room;
   logic [ROW_W-1:0]  col_sum;
   logic [ROW_W-1:0]  row_next;
   logic [2:0]        pos_next;
   logic [1:0]        pos_step;
   logic              last;

   // Field start takes effect before the byte is decoded
   always_comb begin
      eff_row     = hold_begin_ff ? ROW_W'(hold_field_ff) : row_ff;
      eff_col     = hold_begin_ff ? '0 : col_ff;
      eff_pending = hold_begin_ff ? 1'b0 : pending_ff;
      eff_active  = hold_begin_ff ? 1'b1 : active_ff;
   end

   assign go       = hold_valid_ff && out_free;
   assign sym0     = get_symbol(hold_byte_ff, hold_pos_ff);
   assign sym1     = get_symbol(hold_byte_ff, hold_pos_ff + 2'd1);
   assign sym_last = get_symbol(hold_byte_ff, 2'd3);
   assign room     = (eff_col < cfg.image_width) ? (cfg.image_width - eff_col)
                                                 : DIM_W'(1);
   assign row_next = eff_row + ROW_STEP;

   // Decode at most one run: a pending count, a single pixel, or zero plus count
   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      pending_in    = pending_ff;
      active_in     = active_ff;
      pos_step      = hold_pos_ff;
      done          = 1'b0;
      take_run      = 1'b0;
      color         = '0;
      count         = '0;
      consume       = 3'd1;
      len_raw       = '0;
      len           = '0;
      col_sum       = '0;
      pos_next      = '0;
      last          = 1'b0;
      if (go) begin
         row_in        = eff_row;
         col_in        = eff_col;
         pending_in    = eff_pending;
         active_in     = eff_active;
         if (cfg.image_width == '0) begin
            done = 1'b1;
         end else if (!eff_active || (eff_row >= ROW_W'(cfg.image_height))) begin
            active_in = 1'b0;
            done      = 1'b1;
         end else if (eff_pending) begin
            take_run = 1'b1;
            count    = sym0;
         end else if (sym0 != '0) begin
            take_run = 1'b1;
            color    = sym0;
         end else if (hold_pos_ff == 2'd3) begin
            // zero at byte end: its count comes with the next byte
            pending_in = 1'b1;
            done       = 1'b1;
         end else begin
            take_run = 1'b1;
            count    = sym1;
            consume  = 3'd2;
         end

         if (take_run) begin
            pending_in = 1'b0;
            len_raw    = LEN_W'(count) + LEN_W'(1);
            len        = (DIM_W'(len_raw) > room) ? room[LEN_W-1:0] : len_raw;
            col_sum    = ROW_W'(eff_col) + ROW_W'(len);
            pos_next   = 3'(hold_pos_ff) + consume;
            if (col_sum >= ROW_W'(cfg.image_width)) begin
               // row complete: drop the rest of the byte
               col_in    = '0;
               row_in    = row_next;
               active_in = row_next < ROW_W'(cfg.image_height);
               done      = 1'b1;
               last      = 1'b1;
            end else begin
               col_in = col_sum[DIM_W-1:0];
               if (pos_next == 3'd4) begin
                  done = 1'b1;
                  last = 1'b1;
               end else if ((pos_next == 3'd3) && (sym_last == '0)) begin
                  // lone trailing zero: leave its count pending
                  pending_in = 1'b1;
                  done       = 1'b1;
                  last       = 1'b1;
               end else begin
                  pos_step = pos_next[1:0];
               end
            end
         end
      end
   end

   // Take a new byte once the held one is finished
   assign in_ready = !hold_valid_ff || (go && done);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      hold_field_in = hold_field_ff;
      hold_begin_in = go ? 1'b0 : hold_begin_ff;
      hold_pos_in   = pos_step;
      if (in_ready) begin
         hold_valid_in = in_valid;
         hold_byte_in  = in_data_byte;
         hold_field_in = in_field_index;
         hold_begin_in = in_begin_field;
         hold_pos_in   = '0;
      end
   end

   // Run record to the output stage
   always_comb begin
      step.emit             = go && take_run;
      step.run.pixel_row    = eff_row[DIM_W-1:0];
      step.run.pixel_column = eff_col;
      step.run.color_index  = color;
      step.run.run_length   = len;
      step.run.last_of_byte = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         hold_begin_ff <= 1'b0;
         hold_pos_ff   <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         pending_ff    <= 1'b0;
         active_ff     <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         hold_begin_ff <= hold_begin_in;
         hold_pos_ff   <= hold_pos_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         pending_ff    <= pending_in;
         active_ff     <= active_in;
      end
   end

   // Payload of the held byte
   always_ff @(posedge clock) begin
      hold_byte_ff  <= hold_byte_in;
      hold_field_ff <= hold_field_in;
   end

endmodule

`default_nettype wire

// ===== sv/itrle_out.sv =====
// ----------------------------------------------------------------------------
// itrle_out - result register
// Holds one run record for the response channel and frees itself when the
// record is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module itrle_out
   import itrle_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire step_type step,
   output logic          out_free,
   output logic          out_valid,
   input  wire logic     out_ready,
   output run_type       out_run
);

   logic    valid_ff, valid_in;
   run_type run_ff, run_in;

   assign out_free = !valid_ff || out_ready;

   // Load a new record when the register is free, else hold
   always_comb begin
      valid_in = valid_ff;
      run_in   = run_ff;
      if (out_free) begin
         valid_in = step.emit;
         if (step.emit) begin
            run_in = step.run;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

   assign out_valid = valid_ff;
   assign out_run   = run_ff;

endmodule

`default_nettype wire

// ===== sv/interlaced_two_bit_rle_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Interlaced two-bit RLE decoder - top level
// Decodes compressed subtitle bytes into run records of row, column, color
// and length for one interlaced field at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries one compressed byte per transaction, with begin_field
//   and field_index marking the first byte of a field. rsp_port carries one
//   run record per transaction; last_of_byte marks the last run of a byte.
//   Width and height are written over the csr_ port (width at 0x0, height
//   at 0x4) while no byte is in flight.
//   A byte is registered on acceptance; once the response register is free,
//   its first run is decoded from the held byte and loaded into the response
//   register, which drives rsp_port.valid.
//   The decoder emits one run per cycle from the held byte while the response
//   register is free; a byte yields up to four runs, or none. The next byte
//   is accepted in the cycle its predecessor finishes.
//   Reset clears the registers, the raster position and both channels; no
//   field is active until a begin_field byte arrives.
//   When the receiver stalls, the response register holds its record and
//   the decoder waits; a byte already accepted stays registered.
// ----------------------------------------------------------------------------
`default_nettype none

module interlaced_two_bit_rle_decoder_top
   import itrle_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   itrle_req_if.sink              req_port,
   itrle_rsp_if.source            rsp_port,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready
);

   cfg_type  cfg;
   step_type step;
   logic     out_free;
   run_type  out_run;

   // Configuration registers
   itrle_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Byte register and run decoder
   itrle_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .in_valid       (req_port.valid),
      .in_ready       (req_port.ready),
      .in_data_byte   (req_port.data_byte),
      .in_begin_field (req_port.begin_field),
      .in_field_index (req_port.field_index),
      .out_free       (out_free),
      .step           (step)
   );

   // Result register
   itrle_out u_out (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .out_free  (out_free),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_run   (out_run)
   );

   assign rsp_port.pixel_row    = out_run.pixel_row;
   assign rsp_port.pixel_column = out_run.pixel_column;
   assign rsp_port.color_index  = out_run.color_index;
   assign rsp_port.run_length   = out_run.run_length;
   assign rsp_port.last_of_byte = out_run.last_of_byte;

endmodule

`default_nettype wire

// ===== sv/itrle_checker.sv =====
// ----------------------------------------------------------------------------
// itrle_checker - port checks for the decoder top level
// Watches the response channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "interlaced_two_bit_rle_decoder_top_defines.svh"
`default_nettype none

module itrle_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_run_length,
   input wire logic       rsp_last_of_byte
);

   // Response held while stalled
   `ITRLE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   // Reset empties the result register
   `ITRLE_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "response valid after reset")

   // A run that is not the last of its byte is followed at once by the next
   `ITRLE_ASSERT(a_byte_continues, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_byte |=> rsp_valid, "byte ended without a last run")

   // Every run covers one to four pixels
   `ITRLE_ASSERT(a_run_length, clock, reset, rsp_valid |-> (rsp_run_length != 3'd0) && (rsp_run_length <= 3'd4), "run length out of range")

endmodule

bind interlaced_two_bit_rle_decoder_top itrle_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_run_length   (rsp_port.run_length),
   .rsp_last_of_byte (rsp_port.last_of_byte)
);

`default_nettype wire
